// ===== hdl/sti_pkg.sv =====
// Shared types and constants for the segment/triangle intersection unit.
package sti_pkg;
   localparam int COORD_WIDTH_DEF   = 24;
   localparam int FRACTION_BITS_DEF = 16;
   localparam int CSR_INDEX_WIDTH   = 3;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_START_X = 3'd0,
      CSR_START_Y = 3'd1,
      CSR_START_Z = 3'd2,
      CSR_END_X   = 3'd3,
      CSR_END_Y   = 3'd4,
      CSR_END_Z   = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic en;
      logic valid;
   } pipe_ctl_type;
endpackage

// ===== hdl/sti_if.sv =====
// Channel interfaces: triangle request, intersection response, register write.
interface sti_req_if #(parameter int COORD_WIDTH = sti_pkg::COORD_WIDTH_DEF);
   logic valid;
   logic ready;
   logic signed [COORD_WIDTH-1:0] vertex_a_x, vertex_a_y, vertex_a_z;
   logic signed [COORD_WIDTH-1:0] vertex_b_x, vertex_b_y, vertex_b_z;
   logic signed [COORD_WIDTH-1:0] vertex_c_x, vertex_c_y, vertex_c_z;
   modport source (output valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y,
                   vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z, input ready);
   modport sink (input valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y,
                 vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z, output ready);
endinterface

interface sti_rsp_if #(parameter int FRACTION_BITS = sti_pkg::FRACTION_BITS_DEF);
   logic valid;
   logic ready;
   logic hit;
   logic [FRACTION_BITS:0] hit_fraction;
   modport source (output valid, hit, hit_fraction, input ready);
   modport sink (input valid, hit, hit_fraction, output ready);
endinterface

interface sti_csr_if #(parameter int COORD_WIDTH = sti_pkg::COORD_WIDTH_DEF);
   logic valid;
   logic ready;
   logic [sti_pkg::CSR_INDEX_WIDTH-1:0] index;
   logic [COORD_WIDTH-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/sti_front.sv =====
// Front stages: edge vectors, cross-product terms, normal and segment cross vector.
module sti_front #(
   parameter int CW = sti_pkg::COORD_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sti_pkg::pipe_ctl_type ctl,
   input  logic signed [CW-1:0]  va [3],
   input  logic signed [CW-1:0]  vb [3],
   input  logic signed [CW-1:0]  vc [3],
   input  logic signed [CW-1:0]  sp [3],
   input  logic signed [CW-1:0]  sq [3],
   output logic                  out_valid,
   output logic signed [CW:0]    ab_o [3],
   output logic signed [CW:0]    ac_o [3],
   output logic signed [CW:0]    ap_o [3],
   output logic signed [CW:0]    qp_o [3],
   output logic signed [2*CW+2:0] n_o [3],
   output logic signed [2*CW+2:0] e_o [3]
);
   import sti_pkg::*;
   localparam int VW = CW + 1;
   localparam int PW = 2 * CW + 2;
   localparam int NW = 2 * CW + 3;

   logic [2:0] vld_ff, vld_in;
   logic signed [VW-1:0] ab1_ff [3], ac1_ff [3], ap1_ff [3], qp1_ff [3];
   logic signed [VW-1:0] ab1_in [3], ac1_in [3], ap1_in [3], qp1_in [3];
   logic signed [VW-1:0] ab2_ff [3], ac2_ff [3], ap2_ff [3], qp2_ff [3];
   logic signed [VW-1:0] ab3_ff [3], ac3_ff [3], ap3_ff [3], qp3_ff [3];
   logic signed [PW-1:0] pn_ff [6], pe_ff [6], pn_in [6], pe_in [6];
   logic signed [NW-1:0] n_ff [3], e_ff [3], n_in [3], e_in [3];

   always_comb begin
      vld_in = {vld_ff[1:0], ctl.valid};
      for (int i = 0; i < 3; i++) begin
         ab1_in[i] = VW'(vb[i]) - VW'(va[i]);
         ac1_in[i] = VW'(vc[i]) - VW'(va[i]);
         ap1_in[i] = VW'(sp[i]) - VW'(va[i]);
         qp1_in[i] = VW'(sp[i]) - VW'(sq[i]);
      end
      // cross terms: x = a1b2 - a2b1, y = a2b0 - a0b2, z = a0b1 - a1b0
      pn_in[0] = PW'(ab1_ff[1]) * PW'(ac1_ff[2]);
      pn_in[1] = PW'(ab1_ff[2]) * PW'(ac1_ff[1]);
      pn_in[2] = PW'(ab1_ff[2]) * PW'(ac1_ff[0]);
      pn_in[3] = PW'(ab1_ff[0]) * PW'(ac1_ff[2]);
      pn_in[4] = PW'(ab1_ff[0]) * PW'(ac1_ff[1]);
      pn_in[5] = PW'(ab1_ff[1]) * PW'(ac1_ff[0]);
      pe_in[0] = PW'(qp1_ff[1]) * PW'(ap1_ff[2]);
      pe_in[1] = PW'(qp1_ff[2]) * PW'(ap1_ff[1]);
      pe_in[2] = PW'(qp1_ff[2]) * PW'(ap1_ff[0]);
      pe_in[3] = PW'(qp1_ff[0]) * PW'(ap1_ff[2]);
      pe_in[4] = PW'(qp1_ff[0]) * PW'(ap1_ff[1]);
      pe_in[5] = PW'(qp1_ff[1]) * PW'(ap1_ff[0]);
      for (int i = 0; i < 3; i++) begin
         n_in[i] = NW'(pn_ff[2*i]) - NW'(pn_ff[2*i+1]);
         e_in[i] = NW'(pe_ff[2*i]) - NW'(pe_ff[2*i+1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ctl.en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         ab1_ff <= ab1_in; ac1_ff <= ac1_in; ap1_ff <= ap1_in; qp1_ff <= qp1_in;
         ab2_ff <= ab1_ff; ac2_ff <= ac1_ff; ap2_ff <= ap1_ff; qp2_ff <= qp1_ff;
         ab3_ff <= ab2_ff; ac3_ff <= ac2_ff; ap3_ff <= ap2_ff; qp3_ff <= qp2_ff;
         pn_ff <= pn_in; pe_ff <= pe_in;
         n_ff <= n_in; e_ff <= e_in;
      end
   end

   assign out_valid = vld_ff[2];
   assign ab_o = ab3_ff;
   assign ac_o = ac3_ff;
   assign ap_o = ap3_ff;
   assign qp_o = qp3_ff;
   assign n_o  = n_ff;
   assign e_o  = e_ff;
endmodule

// ===== hdl/sti_dot.sv =====
// Dot-product stages (split partial products) and the hit test.
module sti_dot #(
   parameter int CW = sti_pkg::COORD_WIDTH_DEF,
   parameter int DW = 3 * CW + 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  sti_pkg::pipe_ctl_type  ctl,
   input  logic signed [CW:0]     ab [3],
   input  logic signed [CW:0]     ac [3],
   input  logic signed [CW:0]     ap [3],
   input  logic signed [CW:0]     qp [3],
   input  logic signed [2*CW+2:0] n [3],
   input  logic signed [2*CW+2:0] e [3],
   output logic                   out_valid,
   output logic                   hit_o,
   output logic signed [DW-1:0]   t_o,
   output logic signed [DW-1:0]   d_o
);
   import sti_pkg::*;
   localparam int NW = 2 * CW + 3;
   localparam int LW = CW + 2;
   localparam int HW = NW - LW;
   localparam int LPW = CW + 1 + LW + 1;
   localparam int HPW = CW + 1 + HW;

   // dot order: 0 d = qp.n, 1 t = ap.n, 2 v = ac.e, 3 u = ab.e (w = -u)
   logic [2:0] vld_ff, vld_in;
   logic signed [CW:0]     opa [4][3];
   logic signed [NW-1:0]   opb [4][3];
   logic signed [LPW-1:0]  lo_ff [4][3], lo_in [4][3];
   logic signed [HPW-1:0]  hi_ff [4][3], hi_in [4][3];
   logic signed [DW-1:0]   dot_ff [4], dot_in [4];
   logic signed [DW:0]     vmu;
   logic                   hit_ff, hit_in;
   logic signed [DW-1:0]   t_ff, d_ff;

   always_comb begin
      vld_in = {vld_ff[1:0], ctl.valid};
      for (int i = 0; i < 3; i++) begin
         opa[0][i] = qp[i]; opb[0][i] = n[i];
         opa[1][i] = ap[i]; opb[1][i] = n[i];
         opa[2][i] = ac[i]; opb[2][i] = e[i];
         opa[3][i] = ab[i]; opb[3][i] = e[i];
      end
      for (int k = 0; k < 4; k++) begin
         for (int i = 0; i < 3; i++) begin
            lo_in[k][i] = LPW'(opa[k][i]) * LPW'($signed({1'b0, opb[k][i][LW-1:0]}));
            hi_in[k][i] = HPW'(opa[k][i]) * HPW'($signed(opb[k][i][NW-1:LW]));
         end
      end
      for (int k = 0; k < 4; k++) begin
         dot_in[k] = '0;
         for (int i = 0; i < 3; i++) begin
            dot_in[k] = dot_in[k] + (DW'(hi_ff[k][i]) <<< LW) + DW'(lo_ff[k][i]);
         end
      end
      vmu = (DW+1)'(dot_ff[2]) - (DW+1)'(dot_ff[3]);
      hit_in = (dot_ff[0] > 0) && !dot_ff[1][DW-1] && (dot_ff[1] <= dot_ff[0])
            && !dot_ff[2][DW-1] && (dot_ff[2] <= dot_ff[0])
            && (dot_ff[3] <= 0) && (vmu <= (DW+1)'(dot_ff[0]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ctl.en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         lo_ff  <= lo_in;
         hi_ff  <= hi_in;
         dot_ff <= dot_in;
         hit_ff <= hit_in;
         t_ff   <= dot_ff[1];
         d_ff   <= dot_ff[0];
      end
   end

   assign out_valid = vld_ff[2];
   assign hit_o = hit_ff;
   assign t_o = t_ff;
   assign d_o = d_ff;
endmodule

// ===== hdl/sti_div.sv =====
// Restoring divider, one quotient bit per stage, for the hit fraction t/d.
module sti_div #(
   parameter int DW = 3 * sti_pkg::COORD_WIDTH_DEF + 8,
   parameter int FB = sti_pkg::FRACTION_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sti_pkg::pipe_ctl_type ctl,
   input  logic                  hit,
   input  logic signed [DW-1:0]  t,
   input  logic signed [DW-1:0]  d,
   output logic                  out_valid,
   output logic                  hit_o,
   output logic [FB:0]           frac_o
);
   import sti_pkg::*;
   localparam int NS = FB + 1;

   logic                 vld_ff [NS], vld_in [NS];
   logic                 hit_ff [NS], hit_in [NS];
   logic signed [DW-1:0] rem_ff [NS], rem_in [NS];
   logic signed [DW-1:0] d_ff [NS], d_in [NS];
   logic [FB:0]          quo_ff [NS], quo_in [NS];
   logic signed [DW-1:0] trial [NS];

   always_comb begin
      for (int s = 0; s < NS; s++) begin
         if (s == 0) begin
            trial[s]  = t;
            d_in[s]   = d;
            hit_in[s] = hit;
            vld_in[s] = ctl.valid;
            quo_in[s] = '0;
         end else begin
            trial[s]  = rem_ff[s-1] <<< 1;
            d_in[s]   = d_ff[s-1];
            hit_in[s] = hit_ff[s-1];
            vld_in[s] = vld_ff[s-1];
            quo_in[s] = quo_ff[s-1] << 1;
         end
         if (trial[s] >= d_in[s]) begin
            rem_in[s] = trial[s] - d_in[s];
            quo_in[s][0] = 1'b1;
         end else begin
            rem_in[s] = trial[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NS; s++) vld_ff[s] <= 1'b0;
      end else if (ctl.en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         hit_ff <= hit_in;
         rem_ff <= rem_in;
         d_ff   <= d_in;
         quo_ff <= quo_in;
      end
   end

   assign out_valid = vld_ff[NS-1];
   assign hit_o  = hit_ff[NS-1];
   assign frac_o = hit_ff[NS-1] ? quo_ff[NS-1] : '0;
endmodule

// ===== hdl/segment_triangle_intersect_unit.sv =====
// Segment/triangle intersection unit, top level.
// Throughput: one triangle per cycle; the whole pipeline advances unless the
// response register holds a word that is not taken.
// Reset (synchronous): all valid bits cleared, segment registers cleared to 0.
module segment_triangle_intersect_unit #(
   parameter int COORD_WIDTH   = sti_pkg::COORD_WIDTH_DEF,
   parameter int FRACTION_BITS = sti_pkg::FRACTION_BITS_DEF
) (
   input logic  clock,
   input logic  reset,
   sti_req_if.sink   req_chan,
   sti_rsp_if.source rsp_chan,
   sti_csr_if.sink   csr_chan
);
   import sti_pkg::*;
   localparam int CW = COORD_WIDTH;
   localparam int DW = 3 * CW + 8;

   logic signed [CW-1:0] sp_ff [3], sq_ff [3];
   logic signed [CW-1:0] va [3], vb [3], vc [3];
   pipe_ctl_type ctl_front, ctl_dot, ctl_div;
   logic en, front_valid, dot_valid, div_valid, dot_hit, div_hit;
   logic signed [CW:0] ab [3], ac [3], ap [3], qp [3];
   logic signed [2*CW+2:0] n [3], e [3];
   logic signed [DW-1:0] t, d;
   logic [FRACTION_BITS:0] frac;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            sp_ff[i] <= '0;
            sq_ff[i] <= '0;
         end
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_START_X: sp_ff[0] <= csr_chan.data;
            CSR_START_Y: sp_ff[1] <= csr_chan.data;
            CSR_START_Z: sp_ff[2] <= csr_chan.data;
            CSR_END_X:   sq_ff[0] <= csr_chan.data;
            CSR_END_Y:   sq_ff[1] <= csr_chan.data;
            CSR_END_Z:   sq_ff[2] <= csr_chan.data;
            default: ;
         endcase
      end
   end
   assign csr_chan.ready = 1'b1;

   assign en = !div_valid || rsp_chan.ready;
   assign req_chan.ready = en;

   assign va[0] = req_chan.vertex_a_x; assign va[1] = req_chan.vertex_a_y;
   assign va[2] = req_chan.vertex_a_z;
   assign vb[0] = req_chan.vertex_b_x; assign vb[1] = req_chan.vertex_b_y;
   assign vb[2] = req_chan.vertex_b_z;
   assign vc[0] = req_chan.vertex_c_x; assign vc[1] = req_chan.vertex_c_y;
   assign vc[2] = req_chan.vertex_c_z;

   assign ctl_front = '{en: en, valid: req_chan.valid};
   assign ctl_dot   = '{en: en, valid: front_valid};
   assign ctl_div   = '{en: en, valid: dot_valid};

   sti_front #(.CW(CW)) u_front (
      .clock, .reset, .ctl(ctl_front), .va, .vb, .vc, .sp(sp_ff), .sq(sq_ff),
      .out_valid(front_valid), .ab_o(ab), .ac_o(ac), .ap_o(ap), .qp_o(qp),
      .n_o(n), .e_o(e)
   );

   sti_dot #(.CW(CW), .DW(DW)) u_dot (
      .clock, .reset, .ctl(ctl_dot), .ab, .ac, .ap, .qp, .n, .e,
      .out_valid(dot_valid), .hit_o(dot_hit), .t_o(t), .d_o(d)
   );

   sti_div #(.DW(DW), .FB(FRACTION_BITS)) u_div (
      .clock, .reset, .ctl(ctl_div), .hit(dot_hit), .t, .d,
      .out_valid(div_valid), .hit_o(div_hit), .frac_o(frac)
   );

   assign rsp_chan.valid        = div_valid;
   assign rsp_chan.hit          = div_hit;
   assign rsp_chan.hit_fraction = frac;
endmodule
